FILE: rtl/pbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

   // field and datapath widths
   localparam int COORDS     = 3;
   localparam int Q_W        = 16;    // Q7.8 coordinate
   localparam int NRM_W      = 16;    // Q1.14 normal component
   localparam int RAD_W      = 15;    // unsigned Q7.8 radius
   localparam int PLANE_REGS = 6;
   localparam int MASK_W     = 6;
   localparam int CFG_W      = 64;
   localparam int CFG_IDX_W  = 3;
   localparam int OFS_LSB    = 48;    // offset field in a plane register

   // internal arithmetic, 22 fraction bits for distances
   localparam int PROD_W      = Q_W + NRM_W;
   localparam int DIST_W      = 34;
   localparam int W_SHIFT     = 14;
   localparam int CORR_W      = DIST_W + NRM_W;
   localparam int CORR_SHIFT  = 28;
   localparam int RND_W       = CORR_W - CORR_SHIFT;
   localparam int DIFF_W      = 24;

   localparam logic signed [CORR_W-1:0] ROUND_BIAS = CORR_W'(64'd1 << (CORR_SHIFT - 1));
   localparam logic signed [DIFF_W-1:0] Q_MAX      = DIFF_W'(32767);
   localparam logic signed [DIFF_W-1:0] Q_MIN      = -DIFF_W'(32768);

   // configuration register indexes
   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_PLANE_0,
      CSR_PLANE_1,
      CSR_PLANE_2,
      CSR_PLANE_3,
      CSR_PLANE_4,
      CSR_PLANE_5,
      CSR_RADIUS
   } csr_index_type;

   // one particle as it travels down the plane stages
   typedef struct packed {
      logic                         valid;
      logic [COORDS-1:0][Q_W-1:0]   pos;
      logic [COORDS-1:0][Q_W-1:0]   vel;
      logic [COORDS-1:0][Q_W-1:0]   orig;
      logic                         freeze;
      logic [MASK_W-1:0]            hit_mask;
      logic                         in_box;
   } item_type;

   // round half up and drop the fraction bits below Q7.8
   function automatic logic signed [RND_W-1:0] round_corr(input logic signed [CORR_W-1:0] x);
      logic signed [CORR_W-1:0] t;
      t = x + ROUND_BIAS;
      return t[CORR_W-1:CORR_SHIFT];
   endfunction

   // clamp to the Q7.8 range
   function automatic logic [Q_W-1:0] sat_q(input logic signed [DIFF_W-1:0] x);
      logic [Q_W-1:0] r;
      if (x > Q_MAX) r = Q_MAX[Q_W-1:0];
      else if (x < Q_MIN) r = Q_MIN[Q_W-1:0];
      else r = x[Q_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pbc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// particle word into the block
interface pbc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] pos_z;
   logic [15:0] vel_x;
   logic [15:0] vel_y;
   logic [15:0] vel_z;
   logic        freeze_velocity;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   freeze_velocity, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   freeze_velocity, output ready);
endinterface

// corrected particle word out of the block
interface pbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] new_pos_x;
   logic [15:0] new_pos_y;
   logic [15:0] new_pos_z;
   logic [15:0] new_vel_x;
   logic [15:0] new_vel_y;
   logic [15:0] new_vel_z;
   logic [5:0]  hit_mask;
   logic        overlaps_box;

   modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                   new_vel_z, hit_mask, overlaps_box, input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                   new_vel_z, hit_mask, overlaps_box, output ready);
endinterface

`default_nettype wire

FILE: rtl/pbc_plane.sv
`timescale 1ns / 1ps
`default_nettype none

module pbc_plane
   import pbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [CFG_W-1:0]  plane_cfg,
   input  wire logic [RAD_W-1:0]  radius,
   input  wire logic [MASK_W-1:0] hit_sel,
   input  wire item_type          item_i,
   output item_type               item_o
);

   logic                      present;
   logic signed [NRM_W-1:0]   nrm [COORDS];
   logic signed [DIST_W-1:0]  ofs_term;
   logic signed [DIST_W-1:0]  rad_term;

   // plane fields, static while words are in flight
   always_comb begin
      for (int k = 0; k < COORDS; k++) begin
         nrm[k] = $signed(plane_cfg[k*NRM_W +: NRM_W]);
      end
      ofs_term = DIST_W'($signed(plane_cfg[OFS_LSB +: Q_W])) <<< W_SHIFT;
      rad_term = $signed({{(DIST_W-RAD_W){1'b0}}, radius}) <<< W_SHIFT;
   end
   assign present = |hit_sel;

   // stage a: normal times position, velocity and original position
   item_type                  a_ff;
   logic signed [PROD_W-1:0]  pp_ff [COORDS];
   logic signed [PROD_W-1:0]  pv_ff [COORDS];
   logic signed [PROD_W-1:0]  po_ff [COORDS];
   logic signed [PROD_W-1:0]  pp_in [COORDS];
   logic signed [PROD_W-1:0]  pv_in [COORDS];
   logic signed [PROD_W-1:0]  po_in [COORDS];

   always_comb begin
      for (int k = 0; k < COORDS; k++) begin
         pp_in[k] = nrm[k] * $signed(item_i.pos[k]);
         pv_in[k] = nrm[k] * $signed(item_i.vel[k]);
         po_in[k] = nrm[k] * $signed(item_i.orig[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff <= item_i;
         pp_ff <= pp_in;
         pv_ff <= pv_in;
         po_ff <= po_in;
      end
   end

   // stage b: penetration depth, normal speed and overlap test
   item_type                  b_ff;
   logic signed [DIST_W-1:0]  pen_ff, pen_in;
   logic signed [DIST_W-1:0]  sp_ff, sp_in;
   logic signed [DIST_W-1:0]  odist;
   logic                      hit_ff, hit_in;
   logic                      vfix_ff, vfix_in;
   logic                      outside_ff, outside_in;

   always_comb begin
      pen_in = DIST_W'(pp_ff[0]) + DIST_W'(pp_ff[1]) + DIST_W'(pp_ff[2]) + ofs_term
               + rad_term;
      sp_in  = DIST_W'(pv_ff[0]) + DIST_W'(pv_ff[1]) + DIST_W'(pv_ff[2]);
      odist  = DIST_W'(po_ff[0]) + DIST_W'(po_ff[1]) + DIST_W'(po_ff[2]) + ofs_term
               - rad_term;
      hit_in     = present && !pen_in[DIST_W-1];
      vfix_in    = !a_ff.freeze && (sp_in > 0);
      outside_in = present && !odist[DIST_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         b_ff <= a_ff;
         pen_ff <= pen_in;
         sp_ff <= sp_in;
         hit_ff <= hit_in;
         vfix_ff <= vfix_in;
         outside_ff <= outside_in;
      end
   end

   // stage c: correction vectors along the normal
   item_type                  c_ff, c_in;
   logic signed [CORR_W-1:0]  cp_ff [COORDS];
   logic signed [CORR_W-1:0]  cv_ff [COORDS];
   logic signed [CORR_W-1:0]  cp_in [COORDS];
   logic signed [CORR_W-1:0]  cv_in [COORDS];
   logic                      chit_ff, cvfix_ff;

   always_comb begin
      c_in          = b_ff;
      c_in.in_box   = b_ff.in_box && !outside_ff;
      c_in.hit_mask = b_ff.hit_mask | (hit_ff ? hit_sel : '0);
      for (int k = 0; k < COORDS; k++) begin
         cp_in[k] = nrm[k] * pen_ff;
         cv_in[k] = nrm[k] * sp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (advance) begin
         c_ff <= c_in;
         cp_ff <= cp_in;
         cv_ff <= cv_in;
         chit_ff <= hit_ff;
         cvfix_ff <= hit_ff && vfix_ff;
      end
   end

   // stage d: round, subtract and saturate
   item_type                  d_ff, d_in;
   logic signed [DIFF_W-1:0]  dp [COORDS];
   logic signed [DIFF_W-1:0]  dv [COORDS];

   always_comb begin
      d_in = c_ff;
      for (int k = 0; k < COORDS; k++) begin
         dp[k] = DIFF_W'($signed(c_ff.pos[k])) - DIFF_W'(round_corr(cp_ff[k]));
         dv[k] = DIFF_W'($signed(c_ff.vel[k])) - DIFF_W'(round_corr(cv_ff[k]));
         if (chit_ff) d_in.pos[k] = sat_q(dp[k]);
         if (cvfix_ff) d_in.vel[k] = sat_q(dv[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (advance) begin
         d_ff <= d_in;
      end
   end

   assign item_o = d_ff;

endmodule

`default_nettype wire

FILE: rtl/particle_box_collision.sv
// particle_box_collision corrects one particle per clock, unless stalled,
// against up to six container planes. Each plane contributes four register
// stages (products, sums, correction products, round and saturate) that a word
// passes through in turn. One stall signal runs through all stages: when rsp_if
// is not ready and the output register is full, every stage holds and
// req_if.ready drops; otherwise the block takes a new word every cycle.
// Plane and radius registers are read live by the stages and must only be
// written while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module particle_box_collision
   import pbc_pkg::*;
#(
   parameter int NUM_PLANES = 6
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   pbc_req_if.sink                   req_if,
   pbc_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CFG_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int LIVE_PLANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
   localparam logic [MASK_W-1:0] PRESENT_MASK = MASK_W'((64'd1 << LIVE_PLANES) - 64'd1);

   // configuration registers
   logic [CFG_W-1:0] plane_ff [PLANE_REGS];
   logic [RAD_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_REGS; i++) plane_ff[i] <= '0;
         radius_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PLANE_0: plane_ff[0] <= csr_wdata;
            CSR_PLANE_1: plane_ff[1] <= csr_wdata;
            CSR_PLANE_2: plane_ff[2] <= csr_wdata;
            CSR_PLANE_3: plane_ff[3] <= csr_wdata;
            CSR_PLANE_4: plane_ff[4] <= csr_wdata;
            CSR_PLANE_5: plane_ff[5] <= csr_wdata;
            CSR_RADIUS:  radius_ff <= csr_wdata[RAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // plane chain
   item_type              chain [NUM_PLANES+1];
   logic [NUM_PLANES:1]   bnd_valid;
   logic                  advance;

   assign advance = !chain[NUM_PLANES].valid || rsp_if.ready;
   assign req_if.ready = advance;

   always_comb begin
      chain[0].valid    = req_if.valid;
      chain[0].pos[0]   = req_if.pos_x;
      chain[0].pos[1]   = req_if.pos_y;
      chain[0].pos[2]   = req_if.pos_z;
      chain[0].vel[0]   = req_if.vel_x;
      chain[0].vel[1]   = req_if.vel_y;
      chain[0].vel[2]   = req_if.vel_z;
      chain[0].orig     = chain[0].pos;
      chain[0].freeze   = req_if.freeze_velocity;
      chain[0].hit_mask = '0;
      chain[0].in_box   = 1'b1;
   end

   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
      logic [CFG_W-1:0]  cfg;
      logic [MASK_W-1:0] sel;

      // planes past the register set are absent and never hit
      if (i < PLANE_REGS) begin : g_reg
         assign cfg = plane_ff[i];
         assign sel = MASK_W'(1) << i;
      end else begin : g_absent
         assign cfg = '0;
         assign sel = '0;
      end

      pbc_plane u_plane (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .plane_cfg (cfg),
         .radius    (radius_ff),
         .hit_sel   (sel),
         .item_i    (chain[i]),
         .item_o    (chain[i+1])
      );
   end

   for (genvar i = 1; i <= NUM_PLANES; i++) begin : g_bnd
      assign bnd_valid[i] = chain[i].valid;
   end

   // result word
   assign rsp_if.valid        = chain[NUM_PLANES].valid;
   assign rsp_if.new_pos_x    = chain[NUM_PLANES].pos[0];
   assign rsp_if.new_pos_y    = chain[NUM_PLANES].pos[1];
   assign rsp_if.new_pos_z    = chain[NUM_PLANES].pos[2];
   assign rsp_if.new_vel_x    = chain[NUM_PLANES].vel[0];
   assign rsp_if.new_vel_y    = chain[NUM_PLANES].vel[1];
   assign rsp_if.new_vel_z    = chain[NUM_PLANES].vel[2];
   assign rsp_if.hit_mask     = chain[NUM_PLANES].hit_mask;
   assign rsp_if.overlaps_box = chain[NUM_PLANES].in_box;

   // checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(bnd_valid))
      else $error("pipeline occupancy changed during a stall");

   a_mask_present: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.hit_mask & ~PRESENT_MASK) == '0))
      else $error("hit reported for an absent plane");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result word valid straight after reset");

endmodule

`default_nettype wire
